### hdl/skvt_pkg.sv
// Shared types and codes for the sorted key/value table.
package skvt_pkg;

    localparam logic FUNC_PUT    = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 9;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic                      ins;
        logic                      upd;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

### hdl/skvt_cell.sv
// One slot of the sorted chain: holds a pair, compares, shifts right on insert, rewrites the value on update.
module skvt_cell (
    input  logic                                 clk,
    input  skvt_pkg::cell_ctrl_t                 ctrl,
    input  logic                                 occ,
    input  logic                                 left_less,
    input  logic signed [skvt_pkg::KEY_W-1:0]    left_key,
    input  logic signed [skvt_pkg::VALUE_W-1:0]  left_value,
    output logic                                 less,
    output logic                                 eq,
    output logic signed [skvt_pkg::KEY_W-1:0]    key,
    output logic signed [skvt_pkg::VALUE_W-1:0]  value
);

    logic signed [skvt_pkg::KEY_W-1:0]   key_reg;
    logic signed [skvt_pkg::KEY_W-1:0]   key_next;
    logic signed [skvt_pkg::VALUE_W-1:0] value_reg;
    logic signed [skvt_pkg::VALUE_W-1:0] value_next;

    assign less  = occ && (key_reg < ctrl.key);
    assign eq    = occ && (key_reg == ctrl.key);
    assign key   = key_reg;
    assign value = value_reg;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.ins && !less)
        begin
            // first slot not below the key takes the new pair, the rest shift
            if (left_less)
            begin
                key_next   = ctrl.key;
                value_next = ctrl.value;
            end
            else
            begin
                key_next   = left_key;
                value_next = left_value;
            end
        end
        else if (ctrl.upd && eq)
        begin
            value_next = ctrl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

### hdl/sorted_key_value_table.sv
// An accepted word passes through P_EXEC and P_FIN; its result is registered onto the ports
// as P_FIN ends (done for one cycle).
// P_EXEC compares all cells and shifts the chain, and P_FIN finishes the registered OR tree
// that returns a lookup hit value.
// busy is high only in the compare/shift cycle; a new word may start while the result forms.
// Reset (rst_n, async, active low) empties the table at once; no clearing pass is needed.
module sorted_key_value_table #(
    parameter int CAPACITY = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 func,
    input  logic signed [skvt_pkg::KEY_W-1:0]    key,
    input  logic signed [skvt_pkg::VALUE_W-1:0]  value,
    output logic                                 busy,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic signed [skvt_pkg::VALUE_W-1:0]  result_value,
    output logic [skvt_pkg::COUNT_W-1:0]         entry_count
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int GROUP   = 16;
    localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

    typedef enum logic [1:0] {
        P_IDLE,
        P_EXEC,
        P_FIN
    } phase_t;

    phase_t                                phase_reg;
    phase_t                                phase_next;
    logic                                  func_reg;
    logic signed [skvt_pkg::KEY_W-1:0]     key_reg;
    logic signed [skvt_pkg::VALUE_W-1:0]   value_reg;
    logic [CNT_W-1:0]                      count_reg;
    logic [1:0]                            stat_reg;
    logic                                  use_tree_reg;
    logic signed [skvt_pkg::VALUE_W-1:0]   echo_reg;
    logic                                  done_reg;
    logic [1:0]                            status_reg;
    logic signed [skvt_pkg::VALUE_W-1:0]   result_reg;
    logic [skvt_pkg::COUNT_W-1:0]          entry_count_reg;
    logic [skvt_pkg::VALUE_W-1:0]          grp_reg  [NGROUPS];
    logic [skvt_pkg::VALUE_W-1:0]          grp_next [NGROUPS];
    logic [skvt_pkg::VALUE_W-1:0]          tree_out;

    logic                                  accept;
    logic                                  exec;
    logic                                  put;
    logic                                  hit;
    logic                                  full;
    logic [1:0]                            stat_next;
    skvt_pkg::cell_ctrl_t                  ctrl;

    logic                                  occ_vec    [CAPACITY];
    logic                                  less_vec   [CAPACITY];
    logic                                  eq_vec     [CAPACITY];
    logic signed [skvt_pkg::KEY_W-1:0]     ckey_vec   [CAPACITY];
    logic signed [skvt_pkg::VALUE_W-1:0]   cval_vec   [CAPACITY];
    logic                                  lless_vec  [CAPACITY];
    logic signed [skvt_pkg::KEY_W-1:0]     lkey_vec   [CAPACITY];
    logic signed [skvt_pkg::VALUE_W-1:0]   lval_vec   [CAPACITY];

    assign busy   = (phase_reg == P_EXEC);
    assign accept = start && !busy;
    assign exec   = (phase_reg == P_EXEC);
    assign put    = (func_reg == skvt_pkg::FUNC_PUT);
    assign full   = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit = hit | eq_vec[i];
        end
    end

    assign ctrl.ins   = exec && put && !hit && !full;
    assign ctrl.upd   = exec && put && hit;
    assign ctrl.key   = key_reg;
    assign ctrl.value = value_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign occ_vec[gi] = (CNT_W'(gi) < count_reg);
            if (gi == 0)
            begin : g_head
                assign lless_vec[gi] = 1'b1;
                assign lkey_vec[gi]  = key_reg;
                assign lval_vec[gi]  = value_reg;
            end
            else
            begin : g_link
                assign lless_vec[gi] = less_vec[gi-1];
                assign lkey_vec[gi]  = ckey_vec[gi-1];
                assign lval_vec[gi]  = cval_vec[gi-1];
            end
            skvt_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occ        (occ_vec[gi]),
                .left_less  (lless_vec[gi]),
                .left_key   (lkey_vec[gi]),
                .left_value (lval_vec[gi]),
                .less       (less_vec[gi]),
                .eq         (eq_vec[gi]),
                .key        (ckey_vec[gi]),
                .value      (cval_vec[gi])
            );
        end
    endgenerate

    // first tree level: OR of the matching cell's value within each group
    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if ((g * GROUP + j) < CAPACITY)
                begin
                    if (eq_vec[g * GROUP + j])
                    begin
                        grp_next[g] = grp_next[g] | cval_vec[g * GROUP + j];
                    end
                end
            end
        end
    end

    always_comb
    begin
        tree_out = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            tree_out = tree_out | grp_reg[g];
        end
    end

    always_comb
    begin
        if (hit)
        begin
            stat_next = skvt_pkg::ST_HIT;
        end
        else if (put && full)
        begin
            stat_next = skvt_pkg::ST_FULL;
        end
        else
        begin
            stat_next = skvt_pkg::ST_MISS;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            P_IDLE:  phase_next = accept ? P_EXEC : P_IDLE;
            P_EXEC:  phase_next = P_FIN;
            P_FIN:   phase_next = accept ? P_EXEC : P_IDLE;
            default: phase_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= P_IDLE;
            count_reg       <= '0;
            done_reg        <= 1'b0;
            func_reg        <= skvt_pkg::FUNC_PUT;
            key_reg         <= '0;
            value_reg       <= '0;
            stat_reg        <= skvt_pkg::ST_HIT;
            use_tree_reg    <= 1'b0;
            echo_reg        <= '0;
            status_reg      <= skvt_pkg::ST_HIT;
            result_reg      <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == P_FIN);
            if (accept)
            begin
                func_reg  <= func;
                key_reg   <= key;
                value_reg <= value;
            end
            if (exec)
            begin
                stat_reg     <= stat_next;
                use_tree_reg <= !put && hit;
                echo_reg     <= value_reg;
                if (ctrl.ins)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (phase_reg == P_FIN)
            begin
                status_reg      <= stat_reg;
                result_reg      <= use_tree_reg ? $signed(tree_out) : echo_reg;
                entry_count_reg <= skvt_pkg::COUNT_W'(count_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            for (int g = 0; g < NGROUPS; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_value = result_reg;
    assign entry_count  = entry_count_reg;

endmodule

### hdl/skvt_chk.sv
// Port-level checks for the sorted key/value table, bound to the top level.
module skvt_chk #(
    parameter int CAPACITY = 256
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 func,
    input logic signed [skvt_pkg::KEY_W-1:0]    key,
    input logic signed [skvt_pkg::VALUE_W-1:0]  value,
    input logic                                 busy,
    input logic                                 done,
    input logic [1:0]                           status,
    input logic signed [skvt_pkg::VALUE_W-1:0]  result_value,
    input logic [skvt_pkg::COUNT_W-1:0]         entry_count
);

    // every accepted word is followed by its done pulse
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result missing three cycles after accept");

    a_busy_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == skvt_pkg::ST_HIT || status == skvt_pkg::ST_MISS ||
                  status == skvt_pkg::ST_FULL))
        else $error("undefined status code");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == skvt_pkg::ST_FULL) |->
            (entry_count == skvt_pkg::COUNT_W'(CAPACITY)))
        else $error("table full reported below capacity");

    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results closer than two cycles");

endmodule

bind sorted_key_value_table skvt_chk #(.CAPACITY(CAPACITY)) u_skvt_chk (.*);
